FILE: src/hcbd_pkg.sv
`default_nettype none

package hcbd_pkg;

  // Defaults and fixed widths
  localparam int SIZE_BITS_DEF = 32;
  localparam int COUNT_BITS    = 32;
  localparam int LEN_BITS      = 31;
  localparam int BYTE_BITS     = 8;
  localparam int ERR_BITS      = 2;
  localparam int CFG_IDX_BITS  = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_FRAMING_MODE = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BODY_LENGTH  = 1'b1;

  // Framing modes
  localparam logic MODE_CHUNKED = 1'b0;
  localparam logic MODE_LENGTH  = 1'b1;

  // Error codes
  localparam logic [ERR_BITS-1:0] ERR_NONE       = 2'd0;
  localparam logic [ERR_BITS-1:0] ERR_AFTER_DONE = 2'd1;
  localparam logic [ERR_BITS-1:0] ERR_OVERFLOW   = 2'd2;

  // Characters
  localparam logic [BYTE_BITS-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_BITS-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_BITS-1:0] CH_SP    = 8'h20;
  localparam logic [BYTE_BITS-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_BITS-1:0] CH_VT    = 8'h0B;
  localparam logic [BYTE_BITS-1:0] CH_FF    = 8'h0C;
  localparam logic [BYTE_BITS-1:0] CH_DIG0  = 8'h30;
  localparam logic [BYTE_BITS-1:0] CH_DIG9  = 8'h39;
  localparam logic [BYTE_BITS-1:0] CH_LOWA  = 8'h61;
  localparam logic [BYTE_BITS-1:0] CH_LOWF  = 8'h66;
  localparam logic [BYTE_BITS-1:0] CH_UPA   = 8'h41;
  localparam logic [BYTE_BITS-1:0] CH_UPF   = 8'h46;

  // Value 16 means "not a hex digit"
  localparam logic [4:0] HEX_NONE = 5'd16;

  typedef struct packed {
    logic [BYTE_BITS-1:0] out_byte;
    logic                 out_valid;
    logic                 message_done;
    logic [ERR_BITS-1:0]  error_code;
  } result_t;

  function automatic logic [4:0] hex_value(input logic [BYTE_BITS-1:0] b);
    logic [BYTE_BITS-1:0] diff;
    begin
      diff = '0;
      if (b >= CH_DIG0 && b <= CH_DIG9) begin
        diff = b - CH_DIG0;
      end else if (b >= CH_LOWA && b <= CH_LOWF) begin
        diff = b - CH_LOWA + 8'd10;
      end else if (b >= CH_UPA && b <= CH_UPF) begin
        diff = b - CH_UPA + 8'd10;
      end else begin
        diff = {3'b000, HEX_NONE};
      end
      hex_value = diff[4:0];
    end
  endfunction

  function automatic logic is_blank(input logic [BYTE_BITS-1:0] b);
    is_blank = (b == CH_SP) || (b == CH_TAB) || (b == CH_LF) ||
               (b == CH_VT) || (b == CH_FF);
  endfunction

endpackage

`default_nettype wire

FILE: src/hcbd_frame.sv
`default_nettype none

module hcbd_frame #(
  parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             step_en,
  input  wire logic [hcbd_pkg::BYTE_BITS-1:0]   in_byte,
  input  wire logic                             seg_end,
  input  wire logic                             framing_mode,
  input  wire logic [hcbd_pkg::LEN_BITS-1:0]    body_length,
  output hcbd_pkg::result_t                     res
);

  typedef enum logic [1:0] {
    PH_LEAD,
    PH_DIGITS,
    PH_CRSEEN,
    PH_DATA
  } phase_t;

  phase_t                           phase_r, phase_nxt;
  logic [SIZE_BITS-1:0]             chunk_left_r, chunk_left_nxt;
  logic [SIZE_BITS-1:0]             size_accum_r, size_accum_nxt;
  logic                             digits_ended_r, digits_ended_nxt;
  logic                             lead_used_r, lead_used_nxt;
  logic [hcbd_pkg::COUNT_BITS-1:0]  byte_count_r, byte_count_nxt;
  logic                             done_flag_r, done_flag_nxt;

  logic [4:0]                       digit;
  logic                             is_hex;
  logic                             acc_ovf;
  logic [SIZE_BITS-1:0]             acc_add;
  logic [SIZE_BITS-1:0]             chunk_dec;
  logic                             do_lead;

  assign digit     = hcbd_pkg::hex_value(in_byte);
  assign is_hex    = (digit != hcbd_pkg::HEX_NONE);
  // a digit does not fit once the top nibble is in use
  assign acc_ovf   = |size_accum_r[SIZE_BITS-1 -: 4];
  assign acc_add   = acc_ovf ? {SIZE_BITS{1'b1}} : {size_accum_r[SIZE_BITS-5:0], digit[3:0]};
  assign chunk_dec = chunk_left_r - {{(SIZE_BITS-1){1'b0}}, 1'b1};

  always_comb begin
    phase_nxt        = phase_r;
    chunk_left_nxt   = chunk_left_r;
    size_accum_nxt   = size_accum_r;
    digits_ended_nxt = digits_ended_r;
    lead_used_nxt    = lead_used_r;
    byte_count_nxt   = byte_count_r;
    done_flag_nxt    = done_flag_r;
    do_lead          = 1'b0;
    res              = '0;

    if (done_flag_r) begin
      res.error_code = hcbd_pkg::ERR_AFTER_DONE;
    end else if (framing_mode == hcbd_pkg::MODE_LENGTH) begin
      if (byte_count_r != {hcbd_pkg::COUNT_BITS{1'b1}}) begin
        byte_count_nxt = byte_count_r + hcbd_pkg::COUNT_BITS'(1);
      end
      res.out_byte  = in_byte;
      res.out_valid = 1'b1;
      if (seg_end && byte_count_nxt == {1'b0, body_length}) begin
        done_flag_nxt = 1'b1;
      end
    end else begin
      case (phase_r)
        PH_LEAD: begin
          if (in_byte == hcbd_pkg::CH_CR) begin
            phase_nxt = PH_CRSEEN;
          end else begin
            do_lead = 1'b1;
          end
        end
        PH_DIGITS: begin
          if (in_byte == hcbd_pkg::CH_CR) begin
            digits_ended_nxt = 1'b1;
            phase_nxt        = PH_CRSEEN;
          end else if (!digits_ended_r) begin
            if (is_hex) begin
              size_accum_nxt = acc_add;
              if (acc_ovf) begin
                res.error_code = hcbd_pkg::ERR_OVERFLOW;
              end
            end else begin
              digits_ended_nxt = 1'b1;
            end
          end
        end
        PH_CRSEEN: begin
          if (in_byte == hcbd_pkg::CH_LF) begin
            if (!lead_used_r) begin
              // opening CR LF of a size line is dropped once
              lead_used_nxt = 1'b1;
              phase_nxt     = PH_LEAD;
            end else begin
              chunk_left_nxt   = size_accum_r;
              size_accum_nxt   = '0;
              digits_ended_nxt = 1'b0;
              lead_used_nxt    = 1'b0;
              if (size_accum_r == '0) begin
                done_flag_nxt = 1'b1;
                phase_nxt     = PH_LEAD;
              end else begin
                phase_nxt = PH_DATA;
              end
            end
          end else if (in_byte == hcbd_pkg::CH_CR) begin
            lead_used_nxt = 1'b1;
          end else if (digits_ended_r) begin
            phase_nxt = PH_DIGITS;
          end else begin
            phase_nxt = PH_LEAD;
            do_lead   = 1'b1;
          end
        end
        default: begin
          res.out_byte   = in_byte;
          res.out_valid  = 1'b1;
          chunk_left_nxt = chunk_dec;
          if (chunk_dec == '0) begin
            phase_nxt     = PH_LEAD;
            lead_used_nxt = 1'b0;
          end
        end
      endcase

      // first non-CR byte of a size line
      if (do_lead) begin
        lead_used_nxt = 1'b1;
        if (!hcbd_pkg::is_blank(in_byte)) begin
          phase_nxt = PH_DIGITS;
          if (is_hex) begin
            size_accum_nxt = acc_add;
            if (acc_ovf) begin
              res.error_code = hcbd_pkg::ERR_OVERFLOW;
            end
          end else begin
            digits_ended_nxt = 1'b1;
          end
        end
      end
    end

    res.message_done = done_flag_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_LEAD;
      chunk_left_r   <= '0;
      size_accum_r   <= '0;
      digits_ended_r <= 1'b0;
      lead_used_r    <= 1'b0;
      byte_count_r   <= '0;
      done_flag_r    <= 1'b0;
    end else if (step_en) begin
      phase_r        <= phase_nxt;
      chunk_left_r   <= chunk_left_nxt;
      size_accum_r   <= size_accum_nxt;
      digits_ended_r <= digits_ended_nxt;
      lead_used_r    <= lead_used_nxt;
      byte_count_r   <= byte_count_nxt;
      done_flag_r    <= done_flag_nxt;
    end
  end

  a_data_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> chunk_left_r != '0)
    else $error("data phase with no bytes left");

  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    done_flag_r |=> done_flag_r)
    else $error("done flag cleared");

  a_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && done_flag_r |-> res.error_code == hcbd_pkg::ERR_AFTER_DONE && !res.out_valid)
    else $error("word after completion not flagged");

  a_pass_clean: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && res.out_valid |-> res.error_code == hcbd_pkg::ERR_NONE)
    else $error("payload word carries an error");

endmodule

`default_nettype wire

FILE: src/http_chunked_body_decoder.sv
`default_nettype none

// Channel  Handshake             Payload
// in       in_valid/in_ready     in_byte, in_segment_end
// out      out_valid/out_ready   out_byte, out_data_valid, out_message_done, out_error_code
// cfg      cfg_wr_en             cfg_index (0 framing_mode, 1 body_length), cfg_data
//
// One word in, one word out; a word is registered on entry, framed through the
// de-framing state, and lands in the output register.
// Throughput is one word per cycle while the output is not stalled.
// Reset (rst_n low, synchronous) empties both registers and clears the framing state.
// A stalled output holds the input register; one word waits there while the
// output register is full.

module http_chunked_body_decoder #(
  parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [hcbd_pkg::BYTE_BITS-1:0]      in_byte,
  input  wire logic                                in_segment_end,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [hcbd_pkg::BYTE_BITS-1:0]           out_byte,
  output logic                                     out_data_valid,
  output logic                                     out_message_done,
  output logic [hcbd_pkg::ERR_BITS-1:0]            out_error_code,
  input  wire logic                                cfg_wr_en,
  input  wire logic [hcbd_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [hcbd_pkg::LEN_BITS-1:0]       cfg_data
);

  logic                              in_vld_r;
  logic [hcbd_pkg::BYTE_BITS-1:0]    in_byte_r;
  logic                              in_seg_r;
  logic                              out_vld_r;
  hcbd_pkg::result_t                 out_res_r;
  hcbd_pkg::result_t                 res;
  logic                              framing_mode_r;
  logic [hcbd_pkg::LEN_BITS-1:0]     body_length_r;
  logic                              advance;

  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  hcbd_frame #(
    .SIZE_BITS(SIZE_BITS)
  ) u_frame (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (advance),
    .in_byte      (in_byte_r),
    .seg_end      (in_seg_r),
    .framing_mode (framing_mode_r),
    .body_length  (body_length_r),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_byte;
      in_seg_r  <= in_segment_end;
    end
    if (advance) begin
      out_res_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      framing_mode_r <= hcbd_pkg::MODE_CHUNKED;
      body_length_r  <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        hcbd_pkg::CFG_FRAMING_MODE: framing_mode_r <= cfg_data[0];
        hcbd_pkg::CFG_BODY_LENGTH:  body_length_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign out_valid        = out_vld_r;
  assign out_byte         = out_res_r.out_byte;
  assign out_data_valid   = out_res_r.out_valid;
  assign out_message_done = out_res_r.message_done;
  assign out_error_code   = out_res_r.error_code;

endmodule

`default_nettype wire
